// ----- hw/rtl/sprb_pkg.sv -----
// shared types, constants and register codes for the sprite resize block
package sprb_pkg;

    // sprite store geometry, depth is a power of two so indexes wrap by masking
    localparam int SPRITE_STORE_BYTES = 4096;
    localparam int STORE_AW           = $clog2(SPRITE_STORE_BYTES);

    // destination frame line pitch in bytes
    localparam int LINE_STRIDE = 320;

    // input operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_X_START   = 3'd0;
    localparam logic [2:0] REG_Y_START   = 3'd1;
    localparam logic [2:0] REG_X_END     = 3'd2;
    localparam logic [2:0] REG_Y_END     = 3'd3;
    localparam logic [2:0] REG_SPR_W     = 3'd4;
    localparam logic [2:0] REG_SPR_H     = 3'd5;
    localparam logic [2:0] REG_KEY       = 3'd6;
    localparam logic [2:0] REG_FB_BASE   = 3'd7;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2
    } t_kind;

    // one queued command
    typedef struct packed {
        t_kind       kind;
        logic [11:0] load_index;
        logic [7:0]  load_value;
    } t_cmd;

    // configuration register set
    typedef struct packed {
        logic [9:0]  x_start;
        logic [9:0]  y_start;
        logic [9:0]  x_end;
        logic [9:0]  y_end;
        logic [6:0]  sprite_width;
        logic [6:0]  sprite_height;
        logic [7:0]  transparent_key;
        logic [23:0] frame_base;
    } t_cfg;

endpackage

// ----- hw/rtl/sprb_ram.sv -----
// generic single write port ram with registered read
module sprb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sprb_front.sv -----
// input side: decodes items and queues commands for the back end
module sprb_front
    import sprb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [23:0] i_tdata,   // load_index[11:0], load_value[19:12], zero pad
    input  logic [1:0]  i_tuser,   // operation[1:0]
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    t_cmd       in_cmd;
    logic       in_keep;
    logic       accept;
    logic       push;

    // decode the operation, unused codes are dropped
    always_comb begin
        in_keep           = 1'b1;
        in_cmd.kind       = CMD_LOAD;
        in_cmd.load_index = i_tdata[11:0];
        in_cmd.load_value = i_tdata[19:12];
        unique case (i_tuser)
            OP_LOAD:  in_cmd.kind = CMD_LOAD;
            OP_START: in_cmd.kind = CMD_START;
            OP_STEP:  in_cmd.kind = CMD_STEP;
            default:  in_keep = 1'b0;
        endcase
    end

    assign o_tready    = (r_count != 2'd2);
    assign accept      = i_tvalid & o_tready;
    assign push        = accept & in_keep;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // queue pointers
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

// ----- hw/rtl/sprb_back.sv -----
// execution side: sprite store, bresenham walk and result register
module sprb_back
    import sprb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,   // fb_address[23:0], color[31:24]
    output logic [0:0]  o_tuser,   // write_enable[0]
    output logic        o_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COL  = 4'b0010,
        ST_ROW  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [10:0]        r_dest_col, n_dest_col;
    logic [10:0]        r_dest_row, n_dest_row;
    logic [7:0]         r_src_col, n_src_col;
    logic [7:0]         r_src_row, n_src_row;
    logic signed [12:0] r_col_err, n_col_err;
    logic signed [12:0] r_row_err, n_row_err;
    logic [10:0]        r_col_cnt, n_col_cnt;
    logic [10:0]        r_row_cnt, n_row_cnt;
    logic               r_finished, n_finished;
    logic               r_last, n_last;
    logic               r_blank, n_blank;
    logic [23:0]        r_addr, n_addr;
    logic               r_out_valid, n_out_valid;
    logic [23:0]        r_out_addr, n_out_addr;
    logic [7:0]         r_out_color, n_out_color;
    logic               r_out_we, n_out_we;
    logic               r_out_last, n_out_last;

    logic [9:0]          dxc, dxr;
    logic [6:0]          dyc, dyr;
    logic signed [12:0]  two_dxc, two_dxr, two_dyc, two_dyr;
    logic signed [12:0]  col_init, row_init;
    logic [6:0]          w_eff;
    logic [15:0]         rd_idx;
    logic [23:0]         step_addr;
    logic                ram_we, ram_re;
    logic [7:0]          ram_rdata;
    logic [7:0]          res_color;

    // spans and error terms from the current registers
    always_comb begin
        dxc      = (i_cfg.x_end > i_cfg.x_start) ? i_cfg.x_end - i_cfg.x_start
                                                 : i_cfg.x_start - i_cfg.x_end;
        dxr      = (i_cfg.y_end > i_cfg.y_start) ? i_cfg.y_end - i_cfg.y_start
                                                 : i_cfg.y_start - i_cfg.y_end;
        dyc      = (i_cfg.sprite_width == 7'd0) ? 7'd0 : i_cfg.sprite_width - 7'd1;
        dyr      = (i_cfg.sprite_height == 7'd0) ? 7'd0 : i_cfg.sprite_height - 7'd1;
        two_dxc  = $signed({2'b00, dxc, 1'b0});
        two_dxr  = $signed({2'b00, dxr, 1'b0});
        two_dyc  = $signed({5'b00000, dyc, 1'b0});
        two_dyr  = $signed({5'b00000, dyr, 1'b0});
        col_init = two_dyc - $signed({3'b000, dxc});
        row_init = two_dyr - $signed({3'b000, dxr});
        w_eff    = (i_cfg.sprite_width == 7'd0) ? 7'd1 : i_cfg.sprite_width;
    end

    // store read index and frame address of the current pixel
    assign rd_idx    = 16'(r_src_row) * 16'(w_eff) + 16'(r_src_col);
    assign step_addr = 24'(i_cfg.frame_base + 24'(r_dest_col)
                           + 24'(r_dest_row) * 24'(LINE_STRIDE));

    sprb_ram #(
        .WIDTH (8),
        .DEPTH (SPRITE_STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.load_index[STORE_AW-1:0]),
        .i_wdata (i_cmd.load_value),
        .i_re    (ram_re),
        .i_raddr (rd_idx[STORE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign res_color = r_blank ? 8'd0 : ram_rdata;

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_dest_col  = r_dest_col;
        n_dest_row  = r_dest_row;
        n_src_col   = r_src_col;
        n_src_row   = r_src_row;
        n_col_err   = r_col_err;
        n_row_err   = r_row_err;
        n_col_cnt   = r_col_cnt;
        n_row_cnt   = r_row_cnt;
        n_finished  = r_finished;
        n_last      = r_last;
        n_blank     = r_blank;
        n_addr      = r_addr;
        n_out_valid = r_out_valid & ~i_tready;
        n_out_addr  = r_out_addr;
        n_out_color = r_out_color;
        n_out_we    = r_out_we;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_LOAD: begin
                            ram_we = 1'b1;
                        end
                        CMD_START: begin
                            n_dest_col = {1'b0, i_cfg.x_start};
                            n_dest_row = {1'b0, i_cfg.y_start};
                            n_src_col  = 8'd0;
                            n_src_row  = 8'd0;
                            n_col_err  = col_init;
                            n_row_err  = row_init;
                            n_col_cnt  = 11'd0;
                            n_row_cnt  = 11'd0;
                            n_finished = 1'b0;
                        end
                        CMD_STEP: begin
                            if (r_finished) begin
                                n_blank = 1'b1;
                                n_last  = 1'b1;
                                n_addr  = 24'd0;
                                n_state = ST_DONE;
                            end else begin
                                n_blank = 1'b0;
                                n_last  = 1'b0;
                                ram_re  = 1'b1;
                                n_addr  = step_addr;
                                if (r_col_cnt < {1'b0, dxc}) begin
                                    n_state = ST_COL;
                                end else if (r_row_cnt < {1'b0, dxr}) begin
                                    n_state = ST_ROW;
                                end else begin
                                    n_finished = 1'b1;
                                    n_last     = 1'b1;
                                    n_state    = ST_DONE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COL: begin
                // one source column per cycle while the error is not negative
                if (!r_col_err[12]) begin
                    n_src_col = r_src_col + 8'd1;
                    n_col_err = r_col_err - two_dxc;
                end else begin
                    n_col_err  = r_col_err + two_dyc;
                    n_dest_col = (i_cfg.x_end > i_cfg.x_start) ? r_dest_col + 11'd1
                                                               : r_dest_col - 11'd1;
                    n_col_cnt  = r_col_cnt + 11'd1;
                    n_state    = ST_DONE;
                end
            end
            ST_ROW: begin
                // one source row per cycle, then restart the column walk
                if (!r_row_err[12]) begin
                    n_src_row = r_src_row + 8'd1;
                    n_row_err = r_row_err - two_dxr;
                end else begin
                    n_row_err  = r_row_err + two_dyr;
                    n_dest_row = (i_cfg.y_end > i_cfg.y_start) ? r_dest_row + 11'd1
                                                               : r_dest_row - 11'd1;
                    n_row_cnt  = r_row_cnt + 11'd1;
                    n_dest_col = {1'b0, i_cfg.x_start};
                    n_src_col  = 8'd0;
                    n_col_err  = col_init;
                    n_col_cnt  = 11'd0;
                    n_state    = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || i_tready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_addr;
                    n_out_color = res_color;
                    n_out_we    = !r_blank && (res_color != i_cfg.transparent_key);
                    n_out_last  = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dest_col  <= 11'd0;
            r_dest_row  <= 11'd0;
            r_src_col   <= 8'd0;
            r_src_row   <= 8'd0;
            r_col_err   <= 13'sd0;
            r_row_err   <= 13'sd0;
            r_col_cnt   <= 11'd0;
            r_row_cnt   <= 11'd0;
            r_finished  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dest_col  <= n_dest_col;
            r_dest_row  <= n_dest_row;
            r_src_col   <= n_src_col;
            r_src_row   <= n_src_row;
            r_col_err   <= n_col_err;
            r_row_err   <= n_row_err;
            r_col_cnt   <= n_col_cnt;
            r_row_cnt   <= n_row_cnt;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_blank     <= n_blank;
        r_addr      <= n_addr;
        r_out_addr  <= n_out_addr;
        r_out_color <= n_out_color;
        r_out_we    <= n_out_we;
        r_out_last  <= n_out_last;
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out_color, r_out_addr};
    assign o_tuser  = r_out_we;
    assign o_tlast  = r_out_last;

endmodule

// ----- hw/rtl/sprite_resize_bresenham.sv -----
// top level of the sprite resize block: configuration registers, front and back
// Sprite bytes are loaded into a 4096 byte store, a start item arms a walk over
// the destination rectangle and each step item returns one pixel: its frame
// address, its sprite color, a write flag that drops for the transparent key,
// and tlast on the final pixel and every step after it. Load and start items
// finish in the idle state. A step reads the registered store in idle, stays in
// the column or row state for the error loop, one skipped column or row per cycle
// (the last pixel and later steps bypass it), then waits in done for the output.
// A two entry queue takes items while a result waits in the output register.
// Load, start and ignored items give no result. Configuration writes are
// always ready and must only come while no item is in flight.
module sprite_resize_bresenham
    import sprb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // load_index[11:0], load_value[19:12], zero pad
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // fb_address[23:0], color[31:24]
    output logic [0:0]  m_axis_tuser,   // write_enable[0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;
    logic cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_start         <= 10'd0;
            r_cfg.y_start         <= 10'd0;
            r_cfg.x_end           <= 10'd0;
            r_cfg.y_end           <= 10'd0;
            r_cfg.sprite_width    <= 7'd1;
            r_cfg.sprite_height   <= 7'd1;
            r_cfg.transparent_key <= 8'd0;
            r_cfg.frame_base      <= 24'd655360;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_X_START: r_cfg.x_start         <= i_cfg_data[9:0];
                REG_Y_START: r_cfg.y_start         <= i_cfg_data[9:0];
                REG_X_END:   r_cfg.x_end           <= i_cfg_data[9:0];
                REG_Y_END:   r_cfg.y_end           <= i_cfg_data[9:0];
                REG_SPR_W:   r_cfg.sprite_width    <= i_cfg_data[6:0];
                REG_SPR_H:   r_cfg.sprite_height   <= i_cfg_data[6:0];
                REG_KEY:     r_cfg.transparent_key <= i_cfg_data[7:0];
                REG_FB_BASE: r_cfg.frame_base      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sprb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    sprb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );

endmodule
